// File: design/jhs_pkg.sv
// Shared constants and types for the Jacobi heat stencil sweep.
package jhs_pkg;

  localparam int COLS      = 32;
  localparam int TEMP_BITS = 16;
  localparam int COL_W     = $clog2(COLS);
  localparam int COLS_W    = $clog2(COLS + 1);
  localparam int ROW_W     = 12;
  localparam int ROWS_W    = 13;
  localparam int MAX_ROWS  = 4096;
  localparam int SUM_W     = 32;
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;

  localparam logic [1:0] REG_AMBIENT_TEMP = 2'd0;
  localparam logic [1:0] REG_GRID_ROWS    = 2'd1;
  localparam logic [1:0] REG_GRID_COLS    = 2'd2;

  typedef logic [TEMP_BITS-1:0] temp_t;

  typedef struct packed {
    temp_t mid;
    temp_t up;
  } col_pair_t;

  typedef struct packed {
    temp_t nv;
    temp_t old;
    logic  count;
    logic  last_cell;
  } stage_t;

endpackage

// File: design/jhs_cell.sv
// One column position of the two-row line buffer chain.
module jhs_cell (
  input  logic               clk,
  input  logic               shift,
  input  logic               load,
  input  jhs_pkg::col_pair_t from_next,
  input  jhs_pkg::col_pair_t fill,
  output jhs_pkg::col_pair_t q
);

  always_ff @(posedge clk) begin
    if (shift) begin
      if (load) begin
        q <= fill;
      end else begin
        q <= from_next;
      end
    end
  end

endmodule

// File: design/jhs_stencil.sv
// Raster counters, line buffer chain, row flush and the four-neighbour average stage.
module jhs_stencil (
  input  logic                        clk,
  input  logic                        rst,
  input  jhs_pkg::temp_t              ambient_temp,
  input  logic [jhs_pkg::ROWS_W-1:0]  grid_rows,
  input  logic [jhs_pkg::COLS_W-1:0]  grid_cols,
  input  logic                        cell_valid,
  input  jhs_pkg::temp_t              cell_temp,
  output logic                        cell_stall,
  input  logic                        out_free,
  output logic                        s1_valid,
  output jhs_pkg::stage_t             s1
);
  import jhs_pkg::*;

  logic [ROW_W-1:0]  row_count;
  logic [COL_W-1:0]  col_count;
  logic              flushing;
  logic [COL_W-1:0]  flush_col;
  logic              flush_up;
  temp_t             left_val;

  logic [ROWS_W-1:0] rows_eff;
  logic [COLS_W-1:0] cols_eff;
  logic [COL_W-1:0]  tail_idx;
  logic              s1_free;
  logic              step_in;
  logic              step_flush;
  logic              shift;
  logic [COLS-1:0]   load_sel;
  col_pair_t         fill;
  col_pair_t         chain   [COLS];
  col_pair_t         next_in [COLS];

  logic [COLS_W-1:0] c_plus;
  logic [COLS_W-1:0] f_plus;
  logic [ROWS_W-1:0] r_ext;
  logic [ROWS_W-1:0] r_plus;
  logic              last_col;
  logic              last_grid;
  logic              flush_end;

  temp_t             up_v;
  temp_t             down_v;
  temp_t             left_v;
  temp_t             right_v;
  logic              produce;
  logic              count_v;
  logic [TEMP_BITS+1:0] nsum;

  always_comb begin
    priority if (grid_rows == '0) begin
      rows_eff = ROWS_W'(1);
    end else if (grid_rows > ROWS_W'(MAX_ROWS)) begin
      rows_eff = ROWS_W'(MAX_ROWS);
    end else begin
      rows_eff = grid_rows;
    end
    priority if (grid_cols == '0) begin
      cols_eff = COLS_W'(1);
    end else if (grid_cols > COLS_W'(COLS)) begin
      cols_eff = COLS_W'(COLS);
    end else begin
      cols_eff = grid_cols;
    end
  end

  assign tail_idx   = COL_W'(cols_eff - COLS_W'(1));
  assign s1_free    = !s1_valid || out_free;
  assign cell_stall = flushing || !s1_free;
  assign step_in    = cell_valid && !cell_stall;
  assign step_flush = flushing && s1_free;
  assign shift      = step_in || step_flush;
  assign load_sel   = shift ? (COLS'(1) << tail_idx) : '0;

  assign fill.mid = cell_temp;
  assign fill.up  = chain[0].mid;

  for (genvar i = 0; i < COLS; i++) begin : g_cell
    if (i < COLS - 1) begin : g_link
      assign next_in[i] = chain[i+1];
    end else begin : g_tail
      assign next_in[i] = fill;
    end
    jhs_cell u_cell (
      .clk       (clk),
      .shift     (shift),
      .load      (load_sel[i]),
      .from_next (next_in[i]),
      .fill      (fill),
      .q         (chain[i])
    );
  end

  assign c_plus    = COLS_W'(col_count) + COLS_W'(1);
  assign f_plus    = COLS_W'(flush_col) + COLS_W'(1);
  assign r_ext     = ROWS_W'(row_count);
  assign r_plus    = r_ext + ROWS_W'(1);
  assign last_col  = c_plus >= cols_eff;
  assign last_grid = last_col && (r_plus >= rows_eff);
  assign flush_end = f_plus >= cols_eff;

  always_comb begin
    if (flushing) begin
      up_v    = flush_up ? chain[0].up : ambient_temp;
      down_v  = ambient_temp;
      left_v  = (flush_col != '0) ? left_val : ambient_temp;
      right_v = (f_plus < cols_eff) ? chain[1].mid : ambient_temp;
      produce = 1'b1;
      count_v = flush_up;
    end else begin
      up_v    = (row_count >= ROW_W'(2)) ? chain[0].up : ambient_temp;
      down_v  = (r_ext < rows_eff) ? cell_temp : ambient_temp;
      left_v  = (col_count != '0) ? left_val : ambient_temp;
      right_v = (c_plus < cols_eff) ? chain[1].mid : ambient_temp;
      produce = (row_count != '0);
      count_v = (row_count >= ROW_W'(2));
    end
    nsum = (TEMP_BITS+2)'(up_v) + (TEMP_BITS+2)'(down_v)
         + (TEMP_BITS+2)'(left_v) + (TEMP_BITS+2)'(right_v);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
      flushing  <= 1'b0;
      flush_col <= '0;
      flush_up  <= 1'b0;
      s1_valid  <= 1'b0;
    end else begin
      if (step_in) begin
        priority if (last_grid) begin
          row_count <= '0;
          col_count <= '0;
          flushing  <= 1'b1;
          flush_col <= '0;
          flush_up  <= (row_count != '0);
        end else if (last_col) begin
          row_count <= row_count + ROW_W'(1);
          col_count <= '0;
        end else begin
          col_count <= col_count + COL_W'(1);
        end
      end
      if (step_flush) begin
        flush_col <= flush_col + COL_W'(1);
        if (flush_end) begin
          flushing <= 1'b0;
        end
      end
      if (shift && produce) begin
        s1_valid <= 1'b1;
      end else if (out_free) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      left_val <= chain[0].mid;
      if (produce) begin
        s1.nv        <= nsum[TEMP_BITS+1:2];
        s1.old       <= chain[0].mid;
        s1.count     <= count_v;
        s1.last_cell <= flushing && flush_end;
      end
    end
  end

endmodule

// File: design/jhs_accum.sv
// Change accumulator and output register for the sweep results.
module jhs_accum (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s1_valid,
  input  jhs_pkg::stage_t            s1,
  output logic                       out_free,
  input  logic                       result_stall,
  output logic                       result_valid,
  output jhs_pkg::temp_t             new_temp,
  output logic [jhs_pkg::SUM_W-1:0]  change_total,
  output logic                       grid_done
);
  import jhs_pkg::*;

  logic [SUM_W-1:0] change_sum;
  logic [SUM_W-1:0] sum_next;
  temp_t            diff;
  logic [SUM_W:0]   acc;
  logic             adv;

  assign out_free = !result_valid || !result_stall;
  assign adv      = s1_valid && out_free;
  assign diff     = (s1.nv >= s1.old) ? (s1.nv - s1.old) : (s1.old - s1.nv);
  assign acc      = (SUM_W+1)'(change_sum) + (SUM_W+1)'(diff);

  always_comb begin
    if (!s1.count) begin
      sum_next = change_sum;
    end else if (acc[SUM_W]) begin
      sum_next = '1;
    end else begin
      sum_next = acc[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      change_sum   <= '0;
    end else begin
      if (adv) begin
        result_valid <= 1'b1;
        change_sum   <= s1.last_cell ? '0 : sum_next;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      new_temp     <= s1.nv;
      change_total <= s1.last_cell ? sum_next : '0;
      grid_done    <= s1.last_cell;
    end
  end

endmodule

// File: design/jacobi_heat_stencil_sweep.sv
// Top level of the Jacobi heat stencil sweep: register port and stencil pipeline.
// A result word is registered in the s1 stage of jhs_stencil and then in the output register.
// One cell word is taken per cycle while cell_stall is low; results trail the input by one grid row.
// The last cell of the grid starts a flush that steps through the columns in use while the output
// is free and emits the final row; cell_stall stays high during it.
// Synchronous reset clears counters, valid flags and the change sum; the line buffer is not cleared.
module jacobi_heat_stencil_sweep (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [jhs_pkg::ADDR_W-1:0]  paddr,
  input  logic [jhs_pkg::DATA_W-1:0]  pwdata,
  output logic [jhs_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  input  logic                        cell_valid,
  output logic                        cell_stall,
  input  logic [15:0]                 cell_temp,
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic [15:0]                 new_temp,
  output logic [31:0]                 change_total,
  output logic                        grid_done
);
  import jhs_pkg::*;

  temp_t             ambient_temp;
  logic [ROWS_W-1:0] grid_rows;
  logic [COLS_W-1:0] grid_cols;
  logic              cfg_write;
  logic [1:0]        reg_idx;
  logic              out_free;
  logic              s1_valid;
  stage_t            s1;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ambient_temp <= '0;
      grid_rows    <= ROWS_W'(1);
      grid_cols    <= COLS_W'(COLS);
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_AMBIENT_TEMP: ambient_temp <= pwdata[TEMP_BITS-1:0];
        REG_GRID_ROWS:    grid_rows    <= pwdata[ROWS_W-1:0];
        REG_GRID_COLS:    grid_cols    <= pwdata[COLS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_AMBIENT_TEMP: prdata = DATA_W'(ambient_temp);
      REG_GRID_ROWS:    prdata = DATA_W'(grid_rows);
      REG_GRID_COLS:    prdata = DATA_W'(grid_cols);
      default:          prdata = '0;
    endcase
  end

  jhs_stencil u_stencil (
    .clk          (clk),
    .rst          (rst),
    .ambient_temp (ambient_temp),
    .grid_rows    (grid_rows),
    .grid_cols    (grid_cols),
    .cell_valid   (cell_valid),
    .cell_temp    (cell_temp),
    .cell_stall   (cell_stall),
    .out_free     (out_free),
    .s1_valid     (s1_valid),
    .s1           (s1)
  );

  jhs_accum u_accum (
    .clk          (clk),
    .rst          (rst),
    .s1_valid     (s1_valid),
    .s1           (s1),
    .out_free     (out_free),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .new_temp     (new_temp),
    .change_total (change_total),
    .grid_done    (grid_done)
  );

endmodule
